[design/srfd_pkg.sv]
package srfd_pkg;

    localparam logic [7:0] OPT_END    = 8'h00;
    localparam logic [7:0] OPT_NOOP   = 8'h01;
    localparam logic [7:0] OPT_LOOSE  = 8'h83;
    localparam logic [7:0] OPT_STRICT = 8'h89;

    localparam logic [5:0] FIXED_HDR     = 6'd20;
    localparam logic [5:0] DST_FIRST     = 6'd16;
    localparam logic [5:0] DST_LAST      = 6'd19;
    localparam logic [5:0] POS_MAX       = 6'd63;
    localparam logic [7:0] ADDR_BYTES    = 8'd4;
    localparam logic [7:0] MIN_OPT_LEN   = 8'd2;
    localparam logic [7:0] MIN_ROUTE_LEN = 8'd2 + ADDR_BYTES;

    typedef enum logic [1:0] {
        OUTCOME_NONE      = 2'd0,
        OUTCOME_FOUND     = 2'd1,
        OUTCOME_MALFORMED = 2'd2,
        OUTCOME_TRUNCATED = 2'd3
    } outcome_t;

    typedef enum logic [4:0] {
        PH_TYPE  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_SKIP  = 5'b00100,
        PH_ROUTE = 5'b01000,
        PH_DONE  = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        route_found;
        logic [31:0] final_dst;
        logic [31:0] header_dst;
        outcome_t    outcome;
    } result_t;

endpackage

[design/ipv4_source_route_final_dst.sv]
// channel   direction  tdata                                  tuser / tlast
// s_axis    in         [7:0] hdr_byte                         tlast: last_byte
// m_axis    out        [31:0] final_dst, [63:32] header_dst   tuser: [0] route_found,
//                                                             [2:1] outcome
// one byte per cycle sustained: input register, one step of byte logic, result register
// a transfer is taken every cycle unless the result register is full and stalled on a last byte
// a result appears on m_axis the cycle after its last byte leaves the input register
// rst_n is asynchronous and returns the parser to byte 0 of a new header
// bytes with no last mark never wait on the output side
module ipv4_source_route_final_dst
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // hdr_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // final_dst, header_dst
    output logic [2:0]  m_axis_tuser    // route_found, outcome
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    srfd_pkg::result_t out_reg;
    srfd_pkg::result_t walk_result;
    logic              process;
    logic              out_free;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || process;

    srfd_walk u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (process),
        .hdr_byte  (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (walk_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= process && in_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && in_last_reg)
        begin
            out_reg <= walk_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.header_dst, out_reg.final_dst};
    assign m_axis_tuser  = {out_reg.outcome, out_reg.route_found};

    a_found_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.route_found == (out_reg.outcome == srfd_pkg::OUTCOME_FOUND))
        else $error("route flag disagrees with outcome");

    a_dst_copy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.route_found |-> out_reg.final_dst == out_reg.header_dst)
        else $error("final destination differs without a route");

    a_in_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !process |=> in_valid_reg)
        else $error("held byte dropped");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready |-> !process)
        else $error("result overwritten while stalled");

endmodule

[design/srfd_walk.sv]
module srfd_walk
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              hdr_byte,
    input  logic                    last_byte,
    output srfd_pkg::result_t       result
);

    logic [5:0]         byte_pos_reg;
    logic [5:0]         byte_pos_next;
    logic [5:0]         hdr_bytes_reg;
    logic [5:0]         hdr_bytes_next;
    logic [31:0]        dst_word_reg;
    logic [31:0]        dst_word_next;
    logic [31:0]        route_word_reg;
    logic [31:0]        route_word_next;
    srfd_pkg::phase_t   phase_reg;
    srfd_pkg::phase_t   phase_next;
    logic [7:0]         left_reg;
    logic [7:0]         left_next;
    logic               kind_reg;
    logic               kind_next;
    srfd_pkg::outcome_t verdict_reg;
    srfd_pkg::outcome_t verdict_next;

    logic               walk_en;
    logic [6:0]         room;
    logic [7:0]         min_len;
    logic [7:0]         left_dec;
    srfd_pkg::outcome_t code;

    always_comb
    begin
        hdr_bytes_next  = hdr_bytes_reg;
        dst_word_next   = dst_word_reg;
        route_word_next = route_word_reg;
        phase_next      = phase_reg;
        left_next       = left_reg;
        kind_next       = kind_reg;
        verdict_next    = verdict_reg;

        if (byte_pos_reg == 6'd0)
        begin
            hdr_bytes_next = {hdr_byte[3:0], 2'b00};
        end
        if (byte_pos_reg >= srfd_pkg::DST_FIRST && byte_pos_reg <= srfd_pkg::DST_LAST)
        begin
            dst_word_next = {dst_word_reg[23:0], hdr_byte};
        end

        room     = {1'b0, hdr_bytes_reg} - {1'b0, byte_pos_reg} + 7'd1;
        min_len  = kind_reg ? srfd_pkg::MIN_ROUTE_LEN : srfd_pkg::MIN_OPT_LEN;
        left_dec = (left_reg != 8'd0) ? left_reg - 8'd1 : left_reg;
        walk_en  = (byte_pos_reg >= srfd_pkg::FIXED_HDR) && (byte_pos_reg < hdr_bytes_reg)
                   && (phase_reg != srfd_pkg::PH_DONE);

        if (walk_en)
        begin
            unique case (phase_reg)
                srfd_pkg::PH_TYPE:
                begin
                    if (hdr_byte == srfd_pkg::OPT_END)
                    begin
                        verdict_next = srfd_pkg::OUTCOME_NONE;
                        phase_next   = srfd_pkg::PH_DONE;
                    end
                    else if (hdr_byte == srfd_pkg::OPT_NOOP)
                    begin
                        phase_next = srfd_pkg::PH_TYPE;
                    end
                    else if ({1'b0, byte_pos_reg} + 7'd1 >= {1'b0, hdr_bytes_reg})
                    begin
                        verdict_next = srfd_pkg::OUTCOME_MALFORMED;
                        phase_next   = srfd_pkg::PH_DONE;
                    end
                    else
                    begin
                        kind_next  = (hdr_byte == srfd_pkg::OPT_LOOSE)
                                     || (hdr_byte == srfd_pkg::OPT_STRICT);
                        phase_next = srfd_pkg::PH_LEN;
                    end
                end
                srfd_pkg::PH_LEN:
                begin
                    if (hdr_byte < min_len || hdr_byte > {1'b0, room})
                    begin
                        verdict_next = srfd_pkg::OUTCOME_MALFORMED;
                        phase_next   = srfd_pkg::PH_DONE;
                    end
                    else
                    begin
                        left_next = hdr_byte - 8'd2;
                        if (kind_reg)
                        begin
                            phase_next = srfd_pkg::PH_ROUTE;
                        end
                        else if (hdr_byte == 8'd2)
                        begin
                            phase_next = srfd_pkg::PH_TYPE;
                        end
                        else
                        begin
                            phase_next = srfd_pkg::PH_SKIP;
                        end
                    end
                end
                srfd_pkg::PH_SKIP:
                begin
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = srfd_pkg::PH_TYPE;
                    end
                end
                srfd_pkg::PH_ROUTE:
                begin
                    if (left_reg <= srfd_pkg::ADDR_BYTES)
                    begin
                        route_word_next = {route_word_reg[23:0], hdr_byte};
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        verdict_next = srfd_pkg::OUTCOME_FOUND;
                        phase_next   = srfd_pkg::PH_DONE;
                    end
                end
                srfd_pkg::PH_DONE:
                begin
                    phase_next = srfd_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        byte_pos_next = (byte_pos_reg == srfd_pkg::POS_MAX) ? byte_pos_reg
                                                             : byte_pos_reg + 6'd1;

        // truncation wins over everything else
        if (byte_pos_next < hdr_bytes_next)
        begin
            code = srfd_pkg::OUTCOME_TRUNCATED;
        end
        else if (hdr_bytes_next < srfd_pkg::FIXED_HDR)
        begin
            code = srfd_pkg::OUTCOME_MALFORMED;
        end
        else if (phase_next == srfd_pkg::PH_DONE)
        begin
            code = verdict_next;
        end
        else
        begin
            code = srfd_pkg::OUTCOME_NONE;
        end

        result.route_found = (code == srfd_pkg::OUTCOME_FOUND);
        result.final_dst   = (code == srfd_pkg::OUTCOME_FOUND) ? route_word_next
                                                               : dst_word_next;
        result.header_dst  = dst_word_next;
        result.outcome     = code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= 6'd0;
            hdr_bytes_reg  <= 6'd0;
            dst_word_reg   <= 32'd0;
            route_word_reg <= 32'd0;
            phase_reg      <= srfd_pkg::PH_TYPE;
            left_reg       <= 8'd0;
            kind_reg       <= 1'b0;
            verdict_reg    <= srfd_pkg::OUTCOME_NONE;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                byte_pos_reg   <= 6'd0;
                hdr_bytes_reg  <= 6'd0;
                dst_word_reg   <= 32'd0;
                route_word_reg <= 32'd0;
                phase_reg      <= srfd_pkg::PH_TYPE;
                left_reg       <= 8'd0;
                kind_reg       <= 1'b0;
                verdict_reg    <= srfd_pkg::OUTCOME_NONE;
            end
            else
            begin
                byte_pos_reg   <= byte_pos_next;
                hdr_bytes_reg  <= hdr_bytes_next;
                dst_word_reg   <= dst_word_next;
                route_word_reg <= route_word_next;
                phase_reg      <= phase_next;
                left_reg       <= left_next;
                kind_reg       <= kind_next;
                verdict_reg    <= verdict_next;
            end
        end
    end

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> byte_pos_reg == 6'd0 && phase_reg == srfd_pkg::PH_TYPE)
        else $error("walker not restarted after a header");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_byte && byte_pos_reg == srfd_pkg::POS_MAX |=> byte_pos_reg == srfd_pkg::POS_MAX)
        else $error("byte position wrapped");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        step && !last_byte && phase_reg == srfd_pkg::PH_DONE |=> phase_reg == srfd_pkg::PH_DONE)
        else $error("walk resumed after a verdict");

endmodule

[bench/srfd_route_checker.sv]
module srfd_route_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // hdr_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,    // final_dst, header_dst
    input  logic [2:0]  m_tuser,    // route_found, outcome
    output int          fail_count,
    output int          pending,
    output int          n_checked,
    output int          n_found,
    output int          n_rejected
);

    logic [5:0]         pos_cnt;
    logic [5:0]         hdr_len;
    logic [31:0]        dst_acc;
    logic [31:0]        route_acc;
    srfd_pkg::phase_t   step;
    logic [7:0]         opt_left;
    logic               opt_is_route;
    srfd_pkg::outcome_t walk_verdict;
    logic               walk_decided;

    srfd_pkg::result_t  awaited_routes[$];

    function automatic void clear_header_state();
        pos_cnt      = '0;
        hdr_len      = '0;
        dst_acc      = '0;
        route_acc    = '0;
        step         = srfd_pkg::PH_TYPE;
        opt_left     = '0;
        opt_is_route = 1'b0;
        walk_verdict = srfd_pkg::OUTCOME_NONE;
        walk_decided = 1'b0;
    endfunction

    function automatic void conclude(input srfd_pkg::outcome_t v);
        walk_verdict = v;
        walk_decided = 1'b1;
        step         = srfd_pkg::PH_DONE;
    endfunction

    function automatic void walk_option(input logic [7:0] b, input logic [5:0] p);
        int         room;
        logic [7:0] need;
        case (step)
            srfd_pkg::PH_TYPE:
            begin
                if (b == srfd_pkg::OPT_END)
                    conclude(srfd_pkg::OUTCOME_NONE);
                else if (b == srfd_pkg::OPT_NOOP)
                    step = srfd_pkg::PH_TYPE;
                else if (int'(p) + 1 >= int'(hdr_len))
                    conclude(srfd_pkg::OUTCOME_MALFORMED);
                else
                begin
                    opt_is_route = (b == srfd_pkg::OPT_LOOSE) || (b == srfd_pkg::OPT_STRICT);
                    step = srfd_pkg::PH_LEN;
                end
            end
            srfd_pkg::PH_LEN:
            begin
                // bytes from the type byte to the end of the header
                room = int'(hdr_len) - int'(p) + 1;
                need = opt_is_route ? srfd_pkg::MIN_ROUTE_LEN : srfd_pkg::MIN_OPT_LEN;
                if (b < need || int'(b) > room)
                    conclude(srfd_pkg::OUTCOME_MALFORMED);
                else
                begin
                    opt_left = b - srfd_pkg::MIN_OPT_LEN;
                    if (opt_is_route)
                        step = srfd_pkg::PH_ROUTE;
                    else if (opt_left == 8'd0)
                        step = srfd_pkg::PH_TYPE;
                    else
                        step = srfd_pkg::PH_SKIP;
                end
            end
            srfd_pkg::PH_SKIP:
            begin
                if (opt_left > 8'd0)
                    opt_left = opt_left - 8'd1;
                if (opt_left == 8'd0)
                    step = srfd_pkg::PH_TYPE;
            end
            srfd_pkg::PH_ROUTE:
            begin
                if (opt_left <= srfd_pkg::ADDR_BYTES)
                    route_acc = {route_acc[23:0], b};
                if (opt_left > 8'd0)
                    opt_left = opt_left - 8'd1;
                if (opt_left == 8'd0)
                    conclude(srfd_pkg::OUTCOME_FOUND);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void take_header_byte(input logic [7:0] b, input logic lst);
        logic [5:0]         p;
        srfd_pkg::outcome_t code;
        srfd_pkg::result_t  r;
        p = pos_cnt;
        if (p == 6'd0)
            hdr_len = {b[3:0], 2'b00};
        if (p >= srfd_pkg::DST_FIRST && p <= srfd_pkg::DST_LAST)
            dst_acc = {dst_acc[23:0], b};
        if (p >= srfd_pkg::FIXED_HDR && p < hdr_len && !walk_decided)
            walk_option(b, p);
        if (pos_cnt < srfd_pkg::POS_MAX)
            pos_cnt = pos_cnt + 6'd1;
        if (lst)
        begin
            if (pos_cnt < hdr_len)
                code = srfd_pkg::OUTCOME_TRUNCATED;
            else if (hdr_len < srfd_pkg::FIXED_HDR)
                code = srfd_pkg::OUTCOME_MALFORMED;
            else if (walk_decided)
                code = walk_verdict;
            else
                code = srfd_pkg::OUTCOME_NONE;
            r.route_found = (code == srfd_pkg::OUTCOME_FOUND);
            r.final_dst   = (code == srfd_pkg::OUTCOME_FOUND) ? route_acc : dst_acc;
            r.header_dst  = dst_acc;
            r.outcome     = code;
            awaited_routes.push_back(r);
            clear_header_state();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        srfd_pkg::result_t exp_r;
        srfd_pkg::result_t got_r;
        if (!rst_n)
        begin
            clear_header_state();
            awaited_routes.delete();
            fail_count = 0;
            pending    = 0;
            n_checked  = 0;
            n_found    = 0;
            n_rejected = 0;
        end
        else
        begin
            // a result always belongs to a last byte taken on an earlier edge
            if (m_tvalid && m_tready)
            begin
                got_r.route_found = m_tuser[0];
                got_r.final_dst   = m_tdata[31:0];
                got_r.header_dst  = m_tdata[63:32];
                got_r.outcome     = srfd_pkg::outcome_t'(m_tuser[2:1]);
                if (awaited_routes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result found=%0d final=%h hdr=%h outcome=%0d",
                                 $realtime, got_r.route_found, got_r.final_dst,
                                 got_r.header_dst, got_r.outcome);
                    fail_count++;
                end
                else
                begin
                    exp_r = awaited_routes.pop_front();
                    n_checked++;
                    if (exp_r.outcome == srfd_pkg::OUTCOME_FOUND)
                        n_found++;
                    if (exp_r.outcome == srfd_pkg::OUTCOME_MALFORMED
                        || exp_r.outcome == srfd_pkg::OUTCOME_TRUNCATED)
                        n_rejected++;
                    if (got_r.route_found !== exp_r.route_found
                        || got_r.final_dst !== exp_r.final_dst
                        || got_r.header_dst !== exp_r.header_dst
                        || got_r.outcome !== exp_r.outcome)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: result mismatch", $realtime);
                            $display("    expected found=%0d final=%h hdr=%h outcome=%0d",
                                     exp_r.route_found, exp_r.final_dst,
                                     exp_r.header_dst, exp_r.outcome);
                            $display("    actual   found=%0d final=%h hdr=%h outcome=%0d",
                                     got_r.route_found, got_r.final_dst,
                                     got_r.header_dst, got_r.outcome);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_header_byte(s_tdata, s_tlast);
            pending = awaited_routes.size();
        end
    end

endmodule

[bench/ipv4_source_route_final_dst_tb.sv]
module ipv4_source_route_final_dst_tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 16;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // hdr_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;             // final_dst, header_dst
    logic [2:0]  m_axis_tuser;             // route_found, outcome

    int fail_count;
    int pending;
    int n_checked;
    int n_found;
    int n_rejected;

    int send_idle = 0;
    int recv_idle = 0;
    int stall_left = 0;
    int bytes_sent = 0;
    int headers_sent = 0;
    int cycles = 0;

    logic [7:0] frame_q[$];

    ipv4_source_route_final_dst dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    srfd_route_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .s_tlast    (s_axis_tlast),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tuser    (m_axis_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .n_checked  (n_checked),
        .n_found    (n_found),
        .n_rejected (n_rejected)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        rand_byte = 8'($urandom_range(255));
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame();
        int last_idx;
        last_idx = frame_q.size() - 1;
        for (int i = 0; i <= last_idx; i++)
            put_byte(frame_q[i], i == last_idx);
        headers_sent++;
    endtask

    task automatic push_rand(input int n);
        repeat (n) frame_q.push_back(rand_byte());
    endtask

    task automatic open_header(input logic [3:0] ihl, input logic [31:0] dst);
        frame_q.delete();
        frame_q.push_back({4'h4, ihl});
        push_rand(15);
        for (int i = 3; i >= 0; i--)
            frame_q.push_back(dst[8*i +: 8]);
    endtask

    task automatic pause_for_results(input int settle);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (settle) @(posedge clk);
        @(negedge clk);
    endtask

    // option area with random content; a generic option may draw a route type with too short a length
    task automatic fill_options(input int area);
        int left;
        int pick;
        int len;
        left = area;
        while (left > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
            begin
                frame_q.push_back(srfd_pkg::OPT_END);
                push_rand(left - 1);
                left = 0;
            end
            else if (pick < 25 || left < 2)
            begin
                frame_q.push_back(srfd_pkg::OPT_NOOP);
                left--;
            end
            else if (pick < 60 && left >= 6)
            begin
                len = int'($urandom_range(left, 6));
                frame_q.push_back($urandom_range(1) ? srfd_pkg::OPT_LOOSE
                                                    : srfd_pkg::OPT_STRICT);
                frame_q.push_back(8'(len));
                push_rand(len - 2);
                left -= len;
            end
            else
            begin
                len = int'($urandom_range(left, 2));
                frame_q.push_back(8'($urandom_range(255, 2)));
                frame_q.push_back(8'(len));
                push_rand(len - 2);
                left -= len;
            end
        end
    endtask

    task automatic rand_header();
        int         kind;
        int         cut;
        logic [3:0] ihl;
        kind = $urandom_range(99);
        if (kind < 88)
        begin
            if ($urandom_range(9) == 0)
                ihl = 4'($urandom_range(15, 10));
            else
                ihl = 4'($urandom_range(9, 5));
            open_header(ihl, $urandom);
            fill_options(int'(ihl) * 4 - 20);
            if (kind < 70)
            begin
                if ($urandom_range(99) < 15)
                    push_rand($urandom_range(8, 1));
            end
            else if ($urandom_range(1))
                frame_q[$urandom_range(frame_q.size() - 1)] = rand_byte();
            else
            begin
                cut = int'($urandom_range(frame_q.size() - 1, 1));
                while (frame_q.size() > cut)
                    frame_q.delete(frame_q.size() - 1);
            end
        end
        else
        begin
            frame_q.delete();
            push_rand($urandom_range(64, 1));
        end
        send_frame();
    endtask

    task automatic run_directed();
        // plain header, all-zero destination
        open_header(4'd5, 32'h0000_0000);
        send_frame();
        // lone last byte with the largest length
        frame_q.delete();
        frame_q.push_back(8'hff);
        send_frame();
        // lone last byte with zero length
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_frame();
        // length below twenty
        open_header(4'd4, 32'hffff_ffff);
        send_frame();
        // truncated header
        open_header(4'd6, $urandom);
        send_frame();
        // loose route then end of list
        open_header(4'd7, $urandom);
        frame_q.push_back(srfd_pkg::OPT_LOOSE);
        frame_q.push_back(8'd7);
        frame_q.push_back(8'd4);
        frame_q.push_back(8'hff);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'ha5);
        frame_q.push_back(8'h5a);
        frame_q.push_back(srfd_pkg::OPT_END);
        send_frame();
        // strict route filling the option area after a no-op
        open_header(4'd8, $urandom);
        frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(srfd_pkg::OPT_STRICT);
        frame_q.push_back(8'd11);
        push_rand(9);
        send_frame();
        // end of list first
        open_header(4'd6, $urandom);
        frame_q.push_back(srfd_pkg::OPT_END);
        push_rand(3);
        send_frame();
        // walk runs out
        open_header(4'd6, $urandom);
        frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(8'h44);
        frame_q.push_back(8'd2);
        send_frame();
        // option length under two
        open_header(4'd6, $urandom);
        frame_q.push_back(8'h44);
        frame_q.push_back(8'd1);
        push_rand(2);
        send_frame();
        // route length under six
        open_header(4'd6, $urandom);
        frame_q.push_back(srfd_pkg::OPT_LOOSE);
        frame_q.push_back(8'd5);
        push_rand(2);
        send_frame();
        // option overruns the area
        open_header(4'd6, $urandom);
        frame_q.push_back(8'h07);
        frame_q.push_back(8'd5);
        push_rand(2);
        send_frame();
        // no room for a length byte
        open_header(4'd6, $urandom);
        frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(8'h07);
        send_frame();
        // bytes past the header, route-like
        open_header(4'd6, $urandom);
        repeat (4) frame_q.push_back(srfd_pkg::OPT_NOOP);
        frame_q.push_back(srfd_pkg::OPT_LOOSE);
        frame_q.push_back(8'd7);
        push_rand(5);
        send_frame();
        // longest header, long route, position saturates
        open_header(4'd15, $urandom);
        frame_q.push_back(srfd_pkg::OPT_STRICT);
        frame_q.push_back(8'd39);
        push_rand(37);
        frame_q.push_back(srfd_pkg::OPT_END);
        push_rand(12);
        send_frame();
        // skip a generic option, find a route, ignore the rest of the area
        open_header(4'd10, $urandom);
        frame_q.push_back(8'h94);
        frame_q.push_back(8'd4);
        push_rand(2);
        frame_q.push_back(srfd_pkg::OPT_LOOSE);
        frame_q.push_back(8'd8);
        push_rand(6);
        frame_q.push_back(8'h44);
        push_rand(7);
        send_frame();
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int b0;
        send_idle = 24;
        recv_idle = 71;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        pause_for_results(0);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 24 : (phase == 1) ? 71 : 0;
            recv_idle = (phase == 0) ? 71 : (phase == 1) ? 24 : 0;
            if (phase == 2)
            begin
                // receiver backs off while short headers keep coming
                stall_left = 300;
                repeat (3)
                begin
                    open_header(4'd5, $urandom);
                    send_frame();
                end
                pause_for_results(0);
            end
            b0 = bytes_sent;
            while (bytes_sent - b0 < 40)
                rand_header();
            pause_for_results(0);
        end

        pause_for_results(SETTLE_CYCLES);

        $display("run covered %0d header bytes in %0d headers over %0d cycles",
                 bytes_sent, headers_sent, cycles);
        $display("results checked %0d: %0d routes found, %0d malformed or truncated",
                 n_checked, n_found, n_rejected);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[ipv4_source_route_final_dst.f]
design/srfd_pkg.sv
design/srfd_walk.sv
design/ipv4_source_route_final_dst.sv
bench/srfd_route_checker.sv
bench/ipv4_source_route_final_dst_tb.sv
